// ===== src/multi_channel_pid_controller_defines.svh =====
// Assertion macros shared by the PID controller RTL.
`ifndef MULTI_CHANNEL_PID_CONTROLLER_DEFINES_SVH
`define MULTI_CHANNEL_PID_CONTROLLER_DEFINES_SVH

// Check a property on every rising edge while out of reset.
`define MCPID_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define MCPID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mcpid_pkg.sv =====
// Types, widths and reset constants shared by the PID controller modules.
package mcpid_pkg;

   localparam int CHANNELS_DEF       = 4;
   localparam int GAIN_FRAC_BITS_DEF = 10;

   localparam int NUM_CFG_CH = 4;
   localparam int CFG_CH_W   = 2;
   localparam int CSR_AW     = 6;
   localparam int CSR_DW     = 64;

   localparam int OUT_W  = 16;
   localparam int ERR_W  = 17;
   localparam int SUM_W  = 32;
   localparam int GAIN_W = 20;
   localparam int OPD_W  = 32;
   localparam int PROD_W = GAIN_W + 1 + OPD_W;
   localparam int ACC_W  = 56;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;

   localparam logic REG_KIND_GAINS  = 1'b0;
   localparam logic REG_KIND_LIMITS = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [GAIN_W-1:0] kd;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kp;
   } gains_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] lo;
      logic signed [OUT_W-1:0] hi;
   } limits_type;

   typedef struct packed {
      gains_type  gains;
      limits_type limits;
   } chan_cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] error_sum;
      logic signed [ERR_W-1:0] error_before_last;
      logic signed [ERR_W-1:0] last_error;
   } hist_type;

   localparam logic [NUM_CFG_CH-1:0][60:0] GAINS_RST = {
      61'd7696581394504,
      61'd135107988821524480,
      61'd1152921505680594944,
      61'd1152921505680594944
   };

   localparam logic [NUM_CFG_CH-1:0][31:0] LIMITS_RST = {
      32'd4288413796,
      32'd3770687296,
      32'd4137683296,
      32'd4137683296
   };

endpackage

// ===== src/mcpid_csr.sv =====
// Configuration register file: per-channel gains, mode and output limits.
module mcpid_csr
   import mcpid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output chan_cfg_type      cfg_out [NUM_CFG_CH]
);

   gains_type  gains_ff  [NUM_CFG_CH];
   limits_type limits_ff [NUM_CFG_CH];

   logic [CFG_CH_W-1:0] reg_ch;
   logic                reg_kind;
   logic                wr_en;

   assign reg_ch     = csr_paddr[CSR_AW-1:CSR_AW-CFG_CH_W];
   assign reg_kind   = csr_paddr[CSR_AW-CFG_CH_W-1];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG_CH; i++) begin
            gains_ff[i]  <= gains_type'(GAINS_RST[i]);
            limits_ff[i] <= limits_type'(LIMITS_RST[i]);
         end
      end else if (wr_en) begin
         case (reg_kind)
            REG_KIND_GAINS:  gains_ff[reg_ch]  <= gains_type'(csr_pwdata[60:0]);
            REG_KIND_LIMITS: limits_ff[reg_ch] <= limits_type'(csr_pwdata[31:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_kind)
         REG_KIND_GAINS:  csr_prdata = CSR_DW'(gains_ff[reg_ch]);
         REG_KIND_LIMITS: csr_prdata = CSR_DW'(limits_ff[reg_ch]);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_CFG_CH; i++) begin
         cfg_out[i].gains  = gains_ff[i];
         cfg_out[i].limits = limits_ff[i];
      end
   end

endmodule

// ===== src/multi_channel_pid_controller.sv =====
// Top level of the four-channel PID controller bank.
`include "multi_channel_pid_controller_defines.svh"

// Each transaction on the req_ channel carries a channel number, a measured
// value and a setpoint; exactly one rsp_ transaction with the clamped drive
// comes back for it, in order. The block takes one transaction per clock
// unless rsp_stall backs the full pipeline up. Stage 1 reads the error
// history memory and forms the operands, stage 2 holds the three gain
// multipliers, stage 3 reads the held-output memory, sums, clamps and
// truncates, and the output register takes the result. Throughput is set
// by the read-modify-write loops on the two per-channel memories; each closes
// in one stage with a one-entry bypass, so back-to-back samples of the same
// channel run at full rate. Both memories start at zero through per-entry
// valid bits, so no clearing pass follows reset. Gains, mode and limits come
// from the csr_ port (8-byte stride, gains then limits per channel) and may be
// written only while no transaction is in flight.
module multi_channel_pid_controller
   import mcpid_pkg::*;
#(
   parameter int CHANNELS       = CHANNELS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CFG_CH_W-1:0]     req_channel,
   input  logic signed [OUT_W-1:0] req_measured,
   input  logic signed [OUT_W-1:0] req_setpoint,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_drive,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_AW-1:0]       csr_paddr,
   input  logic [CSR_DW-1:0]       csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready
);

   localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HELD_W = OUT_W + GAIN_FRAC_BITS;
   localparam logic [CFG_CH_W:0] CH_LIMIT = (CFG_CH_W+1)'(CHANNELS);
   localparam logic [HELD_W:0]   TRUNC_BIAS = (HELD_W+1)'((1 << GAIN_FRAC_BITS) - 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   chan_cfg_type cfg [NUM_CFG_CH];

   mcpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_out     (cfg)
   );

   // ------------------------------------------------------------------
   // Stage enables. A stage loads when it is empty or its occupant moves
   // on, so bubbles collapse; rsp_stall reaches req_stall combinationally.
   // ------------------------------------------------------------------
   logic rsp_valid_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic out_free, en3, en2, en1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign en3       = !s3_valid_ff || out_free;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   // ------------------------------------------------------------------
   // Stage 0: form the error and issue the history read
   // ------------------------------------------------------------------
   logic                    req_in_range;
   logic [CH_AW-1:0]        req_addr;
   logic signed [ERR_W-1:0] req_err;

   assign req_in_range = {1'b0, req_channel} < CH_LIMIT;
   assign req_addr     = req_in_range ? req_channel[CH_AW-1:0] : '0;
   assign req_err      = ERR_W'(req_setpoint) - ERR_W'(req_measured);

   // History memory: last two errors and the error sum per channel
   hist_type         hist_mem [CHANNELS];
   logic [CHANNELS-1:0] hist_vld_ff;
   logic             hist_we;
   logic [CH_AW-1:0] hist_waddr;
   hist_type         hist_wdata;
   logic             hist_fwd_in;

   assign hist_fwd_in = hist_we && (hist_waddr == req_addr);

   logic [CFG_CH_W-1:0]     s1_chan_ff;
   logic                    s1_in_range_ff;
   logic signed [ERR_W-1:0] s1_err_ff;
   hist_type                hist_rd_ff;
   logic                    hist_rd_vld_ff;
   logic                    hist_fwd_ff;
   hist_type                hist_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (en1) begin
         hist_rd_ff <= hist_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hist_fwd_ff <= 1'b0;
         hist_vld_ff <= '0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_valid;
            hist_fwd_ff <= hist_fwd_in;
         end
         if (hist_we) begin
            hist_vld_ff[hist_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_chan_ff       <= req_channel;
         s1_in_range_ff   <= req_in_range;
         s1_err_ff        <= req_err;
         hist_rd_vld_ff   <= hist_vld_ff[req_addr];
         hist_fwd_data_ff <= hist_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: merge the bypass, update history, pick multiplier operands
   // ------------------------------------------------------------------
   hist_type                 hist_cur;
   gains_type                s1_gains;
   logic signed [ERR_W:0]    diff1;
   logic signed [ERR_W+1:0]  diff2;
   logic signed [SUM_W:0]    sum_ext;
   logic signed [SUM_W-1:0]  sum_sat;
   logic signed [OPD_W-1:0]  opa, opb, opc;

   always_comb begin
      if (hist_fwd_ff) begin
         hist_cur = hist_fwd_data_ff;
      end else if (hist_rd_vld_ff) begin
         hist_cur = hist_rd_ff;
      end else begin
         hist_cur = '0;
      end
   end

   assign s1_gains = cfg[s1_chan_ff].gains;
   assign diff1    = (ERR_W+1)'(s1_err_ff) - (ERR_W+1)'(hist_cur.last_error);
   assign diff2    = (ERR_W+2)'(s1_err_ff)
                   - ((ERR_W+2)'(hist_cur.last_error) <<< 1)
                   + (ERR_W+2)'(hist_cur.error_before_last);
   assign sum_ext  = (SUM_W+1)'(hist_cur.error_sum) + (SUM_W+1)'(s1_err_ff);

   // Saturate the error sum at the 32-bit limits
   always_comb begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                  : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_ext[SUM_W-1:0];
      end
   end

   always_comb begin
      hist_wdata.last_error        = s1_err_ff;
      hist_wdata.error_before_last = hist_cur.last_error;
      if (s1_gains.mode == MODE_INCREMENTAL) begin
         hist_wdata.error_sum = hist_cur.error_sum;
         opa = OPD_W'(diff1);
         opb = OPD_W'(s1_err_ff);
         opc = OPD_W'(diff2);
      end else begin
         hist_wdata.error_sum = sum_sat;
         opa = OPD_W'(s1_err_ff);
         opb = sum_sat;
         opc = OPD_W'(diff1);
      end
   end

   // Write back as the transaction leaves stage 1; out-of-range channels
   // leave the state alone.
   assign hist_we    = s1_valid_ff && en2 && s1_in_range_ff;
   assign hist_waddr = s1_chan_ff[CH_AW-1:0];

   // ------------------------------------------------------------------
   // Stage 2: the three gain products
   // ------------------------------------------------------------------
   logic [CFG_CH_W-1:0]     s2_chan_ff;
   logic                    s2_in_range_ff;
   logic                    s2_mode_ff;
   logic [GAIN_W-1:0]       s2_kp_ff, s2_ki_ff, s2_kd_ff;
   logic signed [OPD_W-1:0] s2_opa_ff, s2_opb_ff, s2_opc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_chan_ff     <= s1_chan_ff;
         s2_in_range_ff <= s1_in_range_ff;
         s2_mode_ff     <= s1_gains.mode;
         s2_kp_ff       <= s1_gains.kp;
         s2_ki_ff       <= s1_gains.ki;
         s2_kd_ff       <= s1_gains.kd;
         s2_opa_ff      <= opa;
         s2_opb_ff      <= opb;
         s2_opc_ff      <= opc;
      end
   end

   logic signed [PROD_W-1:0] prod_a, prod_b, prod_c;

   assign prod_a = $signed({1'b0, s2_kp_ff}) * s2_opa_ff;
   assign prod_b = $signed({1'b0, s2_ki_ff}) * s2_opb_ff;
   assign prod_c = $signed({1'b0, s2_kd_ff}) * s2_opc_ff;

   // Held-output memory: read as the transaction enters stage 3
   logic signed [HELD_W-1:0] held_mem [CHANNELS];
   logic [CHANNELS-1:0]      held_vld_ff;
   logic                     held_we;
   logic [CH_AW-1:0]         held_waddr;
   logic signed [HELD_W-1:0] held_wdata;
   logic [CH_AW-1:0]         held_raddr;
   logic                     held_fwd_in;

   assign held_raddr  = s2_in_range_ff ? s2_chan_ff[CH_AW-1:0] : '0;
   assign held_fwd_in = held_we && (held_waddr == held_raddr);

   logic [CFG_CH_W-1:0]      s3_chan_ff;
   logic                     s3_in_range_ff;
   logic                     s3_mode_ff;
   logic signed [PROD_W-1:0] s3_pa_ff, s3_pb_ff, s3_pc_ff;
   logic signed [HELD_W-1:0] held_rd_ff;
   logic                     held_rd_vld_ff;
   logic                     held_fwd_ff;
   logic signed [HELD_W-1:0] held_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_waddr] <= held_wdata;
      end
      if (en3) begin
         held_rd_ff <= held_mem[held_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         held_fwd_ff <= 1'b0;
         held_vld_ff <= '0;
      end else begin
         if (en3) begin
            s3_valid_ff <= s2_valid_ff;
            held_fwd_ff <= held_fwd_in;
         end
         if (held_we) begin
            held_vld_ff[held_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_chan_ff       <= s2_chan_ff;
         s3_in_range_ff   <= s2_in_range_ff;
         s3_mode_ff       <= s2_mode_ff;
         s3_pa_ff         <= prod_a;
         s3_pb_ff         <= prod_b;
         s3_pc_ff         <= prod_c;
         held_rd_vld_ff   <= held_vld_ff[held_raddr];
         held_fwd_data_ff <= held_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: sum, clamp to max then min, truncate toward zero
   // ------------------------------------------------------------------
   logic signed [HELD_W-1:0] held_cur;
   logic signed [ACC_W-1:0]  held_term;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  lim_hi, lim_lo;
   logic signed [ACC_W-1:0]  clip_hi, clip_lo;
   limits_type               s3_lim;
   logic signed [HELD_W:0]   rnd;
   logic signed [HELD_W:0]   shifted;
   logic signed [OUT_W-1:0]  drive;

   always_comb begin
      if (held_fwd_ff) begin
         held_cur = held_fwd_data_ff;
      end else if (held_rd_vld_ff) begin
         held_cur = held_rd_ff;
      end else begin
         held_cur = '0;
      end
      if (s3_mode_ff == MODE_INCREMENTAL) begin
         held_term = ACC_W'(held_cur);
      end else begin
         held_term = '0;
      end
   end

   assign acc = ACC_W'(s3_pa_ff) + ACC_W'(s3_pb_ff) + ACC_W'(s3_pc_ff) + held_term;

   assign s3_lim  = cfg[s3_chan_ff].limits;
   assign lim_hi  = ACC_W'($signed(s3_lim.hi)) <<< GAIN_FRAC_BITS;
   assign lim_lo  = ACC_W'($signed(s3_lim.lo)) <<< GAIN_FRAC_BITS;
   assign clip_hi = (acc > lim_hi) ? lim_hi : acc;
   assign clip_lo = (clip_hi < lim_lo) ? lim_lo : clip_hi;

   // The clamped value always fits the held-output width
   assign held_wdata = clip_lo[HELD_W-1:0];

   // Bias negative values up before the arithmetic shift so it rounds to zero
   always_comb begin
      rnd = (HELD_W+1)'(held_wdata);
      if (held_wdata[HELD_W-1]) begin
         rnd = rnd + $signed(TRUNC_BIAS);
      end
      shifted = rnd >>> GAIN_FRAC_BITS;
      drive   = s3_in_range_ff ? shifted[OUT_W-1:0] : '0;
   end

   assign held_we    = s3_valid_ff && out_free && s3_in_range_ff
                    && (s3_mode_ff == MODE_INCREMENTAL);
   assign held_waddr = s3_chan_ff[CH_AW-1:0];

   // ------------------------------------------------------------------
   // Output register: advance when empty or the result is taken
   // ------------------------------------------------------------------
   logic signed [OUT_W-1:0] rsp_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_drive_ff <= drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `MCPID_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff), "input stalled while a stage is free")
   `MCPID_ASSERT_NEXT(a_accept_enters_s1, clock, reset, req_valid && !req_stall, s1_valid_ff, "accepted transaction did not enter stage 1")
   `MCPID_ASSERT_NEXT(a_s3_holds, clock, reset, s3_valid_ff && !out_free, s3_valid_ff && $stable(s3_chan_ff) && $stable(s3_pa_ff), "stage 3 changed while blocked")
   `MCPID_ASSERT(a_held_fwd_source, clock, reset, $rose(held_fwd_ff) |-> $past(held_we), "held-output bypass set without a write")

endmodule
